### src/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// Button press classifier package
// Shared types, operation and event codes, and register defaults.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  localparam int OpW    = 3;
  localparam int CodeW  = 3;
  localparam int BtnW   = 2;
  localparam int CountW = 8;

  // Operation codes of an input request.
  localparam logic [OpW-1:0] OP_SAMPLE      = 3'd0;
  localparam logic [OpW-1:0] OP_SEC_TICK    = 3'd1;
  localparam logic [OpW-1:0] OP_ARM_MENU    = 3'd2;
  localparam logic [OpW-1:0] OP_FIVE_TICK   = 3'd3;
  localparam logic [OpW-1:0] OP_ARM_REFRESH = 3'd4;

  // Event codes of a result.
  localparam logic [CodeW-1:0] EV_MENU_SHORT      = 3'd0;
  localparam logic [CodeW-1:0] EV_MENU_LONG       = 3'd1;
  localparam logic [CodeW-1:0] EV_UP              = 3'd2;
  localparam logic [CodeW-1:0] EV_DOWN            = 3'd3;
  localparam logic [CodeW-1:0] EV_MENU_TIMEOUT    = 3'd4;
  localparam logic [CodeW-1:0] EV_REFRESH_TIMEOUT = 3'd5;

  // Latched button.
  localparam logic [BtnW-1:0] BTN_NONE = 2'd0;
  localparam logic [BtnW-1:0] BTN_UP   = 2'd1;
  localparam logic [BtnW-1:0] BTN_DOWN = 2'd2;
  localparam logic [BtnW-1:0] BTN_MENU = 2'd3;

  // Configuration register indexes.
  localparam logic REG_SHORT_MIN = 1'b0;
  localparam logic REG_LONG_MIN  = 1'b1;

  localparam logic [CountW-1:0] SHORT_MIN_RESET = 8'd2;
  localparam logic [CountW-1:0] LONG_MIN_RESET  = 8'd15;
  localparam logic [CountW-1:0] HOLD_MAX        = 8'd255;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic              up_pressed;
    logic              down_pressed;
    logic              menu_pressed;
    logic [CountW-1:0] countdown_value;
  } item_t;

  typedef struct packed {
    logic             event_valid;
    logic [CodeW-1:0] event_code;
  } event_t;

  typedef struct packed {
    logic [BtnW-1:0]   held_button;
    logic [CountW-1:0] menu_countdown;
  } status_t;

endpackage

### src/bpdc_engine.sv
// ----------------------------------------------------------------------------
// Button press classifier engine
// Holds the press and countdown state and classifies one request per cycle while fire is high.
// ----------------------------------------------------------------------------
module bpdc_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  bpdc_pkg::item_t               item,
  input  logic [bpdc_pkg::CountW-1:0]   short_min_ticks,
  input  logic [bpdc_pkg::CountW-1:0]   long_min_ticks,
  output bpdc_pkg::event_t              evt,
  output bpdc_pkg::status_t             status
);

  logic [bpdc_pkg::BtnW-1:0]   held_button, held_button_next;
  logic [bpdc_pkg::CountW-1:0] hold_ticks, hold_ticks_next;
  logic [bpdc_pkg::CountW-1:0] menu_countdown, menu_countdown_next;
  logic [bpdc_pkg::CountW-1:0] refresh_countdown, refresh_countdown_next;

  logic [bpdc_pkg::CountW-1:0] ticks_inc;
  logic                        still_held;
  logic                        released;

  always_comb begin
    held_button_next       = held_button;
    hold_ticks_next        = hold_ticks;
    menu_countdown_next    = menu_countdown;
    refresh_countdown_next = refresh_countdown;
    evt                    = '0;
    released               = 1'b0;
    ticks_inc  = (hold_ticks == bpdc_pkg::HOLD_MAX) ? hold_ticks
                                                    : hold_ticks + 8'd1;
    still_held = (held_button == bpdc_pkg::BTN_UP) ? item.up_pressed
                                                   : item.down_pressed;

    unique case (item.operation)
      bpdc_pkg::OP_SAMPLE: begin
        if (held_button == bpdc_pkg::BTN_NONE) begin
          // The latching tick does not count toward the hold time.
          if (item.menu_pressed) begin
            held_button_next = bpdc_pkg::BTN_MENU;
          end else if (item.down_pressed) begin
            held_button_next = bpdc_pkg::BTN_DOWN;
          end else if (item.up_pressed) begin
            held_button_next = bpdc_pkg::BTN_UP;
          end
          hold_ticks_next = '0;
        end else begin
          hold_ticks_next = ticks_inc;
          if (held_button == bpdc_pkg::BTN_MENU) begin
            // An early menu release is ignored and the press keeps counting.
            if (!item.menu_pressed) begin
              if (ticks_inc >= long_min_ticks) begin
                evt      = '{event_valid: 1'b1, event_code: bpdc_pkg::EV_MENU_LONG};
                released = 1'b1;
              end else if (ticks_inc >= short_min_ticks) begin
                evt      = '{event_valid: 1'b1, event_code: bpdc_pkg::EV_MENU_SHORT};
                released = 1'b1;
              end
            end
          end else if (!still_held) begin
            if (ticks_inc >= short_min_ticks) begin
              evt.event_valid = 1'b1;
              evt.event_code  = (held_button == bpdc_pkg::BTN_UP) ? bpdc_pkg::EV_UP
                                                                  : bpdc_pkg::EV_DOWN;
            end
            released = 1'b1;
          end
          if (released) begin
            hold_ticks_next     = '0;
            held_button_next    = bpdc_pkg::BTN_NONE;
            menu_countdown_next = '0;
          end
        end
      end
      bpdc_pkg::OP_SEC_TICK: begin
        if (menu_countdown != '0) begin
          menu_countdown_next = menu_countdown - 8'd1;
          if (menu_countdown == 8'd1) begin
            evt = '{event_valid: 1'b1, event_code: bpdc_pkg::EV_MENU_TIMEOUT};
          end
        end
      end
      bpdc_pkg::OP_ARM_MENU: begin
        menu_countdown_next = item.countdown_value;
      end
      bpdc_pkg::OP_FIVE_TICK: begin
        if (refresh_countdown != '0) begin
          refresh_countdown_next = refresh_countdown - 8'd1;
          if (refresh_countdown == 8'd1) begin
            evt = '{event_valid: 1'b1, event_code: bpdc_pkg::EV_REFRESH_TIMEOUT};
          end
        end
      end
      bpdc_pkg::OP_ARM_REFRESH: begin
        refresh_countdown_next = item.countdown_value;
      end
      default: begin
        // Unused operation codes leave everything as it is.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_button       <= bpdc_pkg::BTN_NONE;
      hold_ticks        <= '0;
      menu_countdown    <= '0;
      refresh_countdown <= '0;
    end else if (fire) begin
      held_button       <= held_button_next;
      hold_ticks        <= hold_ticks_next;
      menu_countdown    <= menu_countdown_next;
      refresh_countdown <= refresh_countdown_next;
    end
  end

  assign status = '{held_button: held_button, menu_countdown: menu_countdown};

endmodule

### src/button_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// Button press duration classifier
// Classifies menu, up and down presses by hold time and runs two countdowns.
// ----------------------------------------------------------------------------
// Each input request is a sample tick, a one-second tick, a five-second tick
// or an arm command, and gives exactly one result: an event flag in m_tuser
// and an event code in m_tdata (zero when there is no event). The block takes
// one request per clock unless a stall at the output holds it back. A request
// is held in the input register, and its result is then presented from the
// result register. The classification itself is a single level of compares
// and increments between those two registers. Both registers move together,
// so a request is taken while a finished result still waits for m_tready, and
// a stall at the output only holds the input side once both registers are
// full. The thresholds short_min_ticks and long_min_ticks are to be written
// through the cfg port only while the block is idle; the block itself does
// not enforce this. Reset loads 2 and 15.
module button_press_duration_classifier (
  input  logic        clk,
  input  logic        rst,
  // Input requests.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] up_pressed, [1] down_pressed,
                                 // [2] menu_pressed, [10:3] countdown_value
  input  logic [2:0]  s_tuser,   // [2:0] operation
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] event_code
  output logic        m_tuser,   // [0] event_valid
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [bpdc_pkg::CountW-1:0] short_min_ticks;
  logic [bpdc_pkg::CountW-1:0] long_min_ticks;

  logic              in_valid;
  bpdc_pkg::item_t   in_item;
  logic              out_valid;
  bpdc_pkg::event_t  out_event;

  logic              advance;
  bpdc_pkg::event_t  evt;
  bpdc_pkg::status_t status;

  // The held request moves on when the result register is free or drains now.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_min_ticks <= bpdc_pkg::SHORT_MIN_RESET;
      long_min_ticks  <= bpdc_pkg::LONG_MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpdc_pkg::REG_SHORT_MIN: short_min_ticks <= cfg_data;
        bpdc_pkg::REG_LONG_MIN:  long_min_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= '{operation:       s_tuser,
                   up_pressed:      s_tdata[0],
                   down_pressed:    s_tdata[1],
                   menu_pressed:    s_tdata[2],
                   countdown_value: s_tdata[10:3]};
    end
  end

  bpdc_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .item            (in_item),
    .short_min_ticks (short_min_ticks),
    .long_min_ticks  (long_min_ticks),
    .evt             (evt),
    .status          (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= evt;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_event.event_valid;
  assign m_tdata  = {5'd0, out_event.event_code};

`ifndef SYNTHESIS
  // A button event always ends the press and clears the menu countdown.
  a_release_clears : assert property (@(posedge clk) disable iff (rst)
    advance && evt.event_valid &&
    (evt.event_code == bpdc_pkg::EV_MENU_SHORT || evt.event_code == bpdc_pkg::EV_MENU_LONG ||
     evt.event_code == bpdc_pkg::EV_UP || evt.event_code == bpdc_pkg::EV_DOWN)
    |=> status.held_button == bpdc_pkg::BTN_NONE && status.menu_countdown == '0)
    else $error("button event did not release the press");

  // A result without an event carries a zero code.
  a_quiet_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("event code set without an event");

  // An empty result register never holds back the input side.
  a_no_false_stall : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with an empty result register");

  // A menu timeout event fires only from a menu countdown that was at one.
  a_menu_timeout : assert property (@(posedge clk) disable iff (rst)
    advance && evt.event_valid && evt.event_code == bpdc_pkg::EV_MENU_TIMEOUT
    |-> status.menu_countdown == 8'd1)
    else $error("menu timeout without an expiring countdown");
`endif

endmodule
